// File: sv/arc_pkg.sv
`default_nettype none

package arc_pkg;

    // Fixed field widths of the item and result formats.
    localparam int NUM_CORES_DEF = 4;
    localparam int CFG_CORES     = 4;
    localparam int FUNC_W        = 2;
    localparam int CORE_W        = 2;
    localparam int TIME_W        = 32;
    localparam int NOW_W         = 64;
    localparam int ALPHA_W       = 8;
    localparam int PROD_W        = TIME_W + ALPHA_W;
    localparam int MASK_W        = 4;
    localparam int CB_W          = 8;
    localparam int ALU_W         = 64;

    localparam int S_TDATA_W = ((CORE_W + TIME_W + TIME_W + NOW_W + 7) / 8) * 8;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = ((MASK_W + CB_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Bit positions inside s_tdata.
    localparam int CORE_LSB    = 0;
    localparam int ELAPSED_LSB = CORE_LSB + CORE_W;
    localparam int NOMINAL_LSB = ELAPSED_LSB + TIME_W;
    localparam int NOW_LSB     = NOMINAL_LSB + TIME_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_MILESTONE = 2'd0,
        FN_FINISH    = 2'd1,
        FN_TICK      = 2'd2
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ALPHA0  = 3'd0,
        REG_ALPHA1  = 3'd1,
        REG_ALPHA2  = 3'd2,
        REG_ALPHA3  = 3'd3,
        REG_MARGIN0 = 3'd4,
        REG_MARGIN1 = 3'd5,
        REG_MARGIN2 = 3'd6,
        REG_MARGIN3 = 3'd7
    } cfg_reg_t;

    // Decision handed from the sequencer to the policy logic.
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_HALT   = 3'd2,
        OP_AHEAD  = 3'd3,
        OP_FINISH = 3'd4,
        OP_HOLD   = 3'd5,
        OP_FREE   = 3'd6
    } pol_op_t;

    typedef struct packed {
        pol_op_t           op;
        logic [CORE_W-1:0] core;
        logic              arm;
    } pol_req_t;

    typedef struct packed {
        logic [CB_W-1:0]   change;
        logic [MASK_W-1:0] mask;
    } pol_res_t;

endpackage

`default_nettype wire

// File: sv/arc_alu.sv
`default_nettype none

// Shared add/subtract unit. On a subtract, carry high means a >= b.
module arc_alu (
    input  wire logic [arc_pkg::ALU_W-1:0] a,
    input  wire logic [arc_pkg::ALU_W-1:0] b,
    input  wire logic                      sub,
    output logic      [arc_pkg::ALU_W-1:0] res,
    output logic                           carry
);
    import arc_pkg::*;

    logic [ALU_W-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign {carry, res} = {1'b0, a} + {1'b0, b_op} + {{ALU_W{1'b0}}, sub};

endmodule

`default_nettype wire

// File: sv/arc_policy.sv
`default_nettype none

// Halt and release decisions over all cores for one item.
module arc_policy #(
    parameter  int NUM_CORES = arc_pkg::NUM_CORES_DEF,
    localparam int LVL_W     = $clog2(NUM_CORES + 1)
) (
    input  wire arc_pkg::pol_req_t                 req,
    input  wire logic [arc_pkg::MASK_W-1:0]        mask,
    input  wire logic [arc_pkg::CB_W-1:0]          change,
    input  wire logic [LVL_W-1:0]                  lvl [NUM_CORES],
    input  wire logic [NUM_CORES-1:0]              dl_set,
    output arc_pkg::pol_res_t                      res,
    output logic      [LVL_W-1:0]                  lvl_c_next
);
    import arc_pkg::*;

    localparam int CIDX_W = $clog2(NUM_CORES);

    logic [MASK_W-1:0] mask_n;
    logic [CB_W-1:0]   cb_n;
    logic [LVL_W-1:0]  lvl_mod [NUM_CORES];
    logic [LVL_W-1:0]  lvl_c;
    logic [LVL_W-1:0]  start;
    logic [CIDX_W-1:0] ci;
    logic              core_ok;
    logic              blocked;

    assign ci      = req.core[CIDX_W-1:0];
    assign core_ok = ({1'b0, req.core} < (CORE_W + 1)'(NUM_CORES));
    assign lvl_c   = core_ok ? lvl[ci] : LVL_W'(NUM_CORES);

    always_comb begin
        mask_n     = mask;
        cb_n       = change;
        lvl_mod    = lvl;
        lvl_c_next = lvl_c;
        start      = LVL_W'(NUM_CORES);
        blocked    = 1'b0;
        case (req.op)
            OP_CLEAR: begin
                cb_n = '0;
            end
            OP_HALT: begin
                cb_n = '0;
                if (lvl_c > LVL_W'(req.core) + LVL_W'(1)) begin
                    lvl_c_next = lvl_c - LVL_W'(1);
                end
                for (int k = 0; k < NUM_CORES; k++) begin
                    if (LVL_W'(k) >= lvl_c_next && !mask_n[k]) begin
                        mask_n[k] = 1'b1;
                        cb_n[k]   = 1'b1;
                    end
                end
            end
            OP_AHEAD, OP_FINISH: begin
                cb_n       = '0;
                start      = (req.op == OP_AHEAD) ? lvl_c : LVL_W'(req.core);
                lvl_c_next = LVL_W'(NUM_CORES);
                lvl_mod[ci] = lvl_c_next;
                for (int k = 0; k < NUM_CORES; k++) begin
                    blocked = dl_set[k];
                    for (int m = 0; m < NUM_CORES; m++) begin
                        if (lvl_mod[m] <= LVL_W'(k)) begin
                            blocked = 1'b1;
                        end
                    end
                    if (LVL_W'(k) >= start && !blocked && mask_n[k]) begin
                        mask_n[k]        = 1'b0;
                        cb_n[MASK_W + k] = 1'b1;
                    end
                end
                if (req.op == OP_AHEAD && req.arm) begin
                    cb_n[{1'b0, req.core}] = 1'b1;
                end
            end
            OP_HOLD: begin
                if (!mask_n[req.core]) begin
                    mask_n[req.core]       = 1'b1;
                    cb_n[{1'b0, req.core}] = 1'b1;
                end
            end
            OP_FREE: begin
                if (mask_n[req.core]) begin
                    mask_n[req.core]                      = 1'b0;
                    cb_n[3'(MASK_W) + {1'b0, req.core}]   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.mask   = mask_n;
        res.change = cb_n;
    end

endmodule

`default_nettype wire

// File: sv/adaptive_core_halt_regulator.sv
`default_nettype none

// Channel   Dir  Ports                        Contents (lowest bit first)
// -------   ---  ---------------------------  -----------------------------------------
// event in  in   s_tvalid s_tready s_tdata    core_id, elapsed_time, nominal_progress, now
//                s_tuser                      func
// result    out  m_tvalid m_tready m_tdata    halted_cores, decision_bits
// config    in   cfg_we cfg_addr cfg_wdata    alpha_core0..3 at 0..3, margin_core0..3 at 4..7
//
// One item is worked at a time. A milestone steps through MUL and CMP, then to APPLY on
// schedule, through SLK when behind, RES, DST and DL when ahead; a finish or an
// ignored item goes straight to APPLY and a tick through TICK, the steps sharing the one
// 64-bit adder. A result waiting in the output register holds the last step until it is
// taken. Reset (aresetn low at a clock edge) clears the halt state, slack and deadlines,
// sets the levels to the core count, every alpha register to one and clears the margins.
module adaptive_core_halt_regulator #(
    parameter int NUM_CORES = arc_pkg::NUM_CORES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // core_id[1:0], elapsed_time[33:2], nominal_progress[65:34], now[129:66], zero pad
    input  wire logic [arc_pkg::S_TDATA_W-1:0]  s_tdata,
    // func[1:0]
    input  wire logic [arc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // halted_cores[3:0], decision_bits[11:4], zero pad
    output logic      [arc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [arc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [arc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import arc_pkg::*;

    localparam int LVL_W  = $clog2(NUM_CORES + 1);
    localparam int CIDX_W = $clog2(NUM_CORES);

    // The sequencer walks one item through the shared adder, one operation per state.
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_CMP   = 10'b0000000100,
        ST_SLK   = 10'b0000001000,
        ST_RES   = 10'b0000010000,
        ST_DST   = 10'b0000100000,
        ST_DL    = 10'b0001000000,
        ST_TICK  = 10'b0010000000,
        ST_APPLY = 10'b0100000000,
        ST_SPARE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [ALPHA_W-1:0] alpha_reg  [CFG_CORES];
    logic [TIME_W-1:0]  margin_reg [CFG_CORES];

    // Regulator state.
    logic [MASK_W-1:0]  halt_mask_reg;
    logic [CB_W-1:0]    change_reg;
    logic [LVL_W-1:0]   level_reg    [NUM_CORES];
    logic [TIME_W-1:0]  last_slack_reg [NUM_CORES];
    logic [NOW_W-1:0]   deadline_reg [NUM_CORES];

    // Item in flight.
    logic [CORE_W-1:0]  core_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [TIME_W-1:0]  nominal_reg;
    logic [NOW_W-1:0]   now_reg;
    logic [TIME_W-1:0]  setpoint_reg;
    logic [TIME_W-1:0]  slack_reg;
    logic [TIME_W-1:0]  resume_reg;
    logic [NOW_W-1:0]   new_dl_reg;
    logic               arm_reg;
    pol_op_t            op_reg;

    // Result register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [CIDX_W-1:0]   ci;
    logic [NUM_CORES-1:0] dl_set;
    logic [PROD_W-1:0]   product;
    logic [ALU_W-1:0]    alu_a, alu_b, alu_res;
    logic                alu_sub, alu_carry;
    logic                res_zero;
    logic                out_free;
    logic                in_fire;
    logic [CORE_W-1:0]   in_core;
    logic                in_core_ok;
    pol_req_t            pol_req;
    pol_res_t            pol_res;
    logic [LVL_W-1:0]    pol_lvl_c;

    assign ci         = core_reg[CIDX_W-1:0];
    assign in_core    = s_tdata[CORE_LSB +: CORE_W];
    assign in_core_ok = ({1'b0, in_core} < (CORE_W + 1)'(NUM_CORES));
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // A stored deadline of zero means none is armed.
    always_comb begin
        for (int k = 0; k < NUM_CORES; k++) begin
            dl_set[k] = |deadline_reg[k];
        end
    end

    // Setpoint: nominal progress scaled by alpha, kept modulo 2^32.
    assign product = nominal_reg * {{TIME_W{1'b0}}, alpha_reg[core_reg]};

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (state_reg)
            ST_CMP: begin
                alu_a = ALU_W'(elapsed_reg);
                alu_b = ALU_W'(setpoint_reg);
            end
            ST_SLK: begin
                alu_a = ALU_W'(slack_reg);
                alu_b = ALU_W'(last_slack_reg[ci]);
            end
            ST_RES: begin
                alu_a = ALU_W'(setpoint_reg);
                alu_b = ALU_W'(margin_reg[core_reg]);
            end
            ST_DST: begin
                alu_a = ALU_W'(resume_reg);
                alu_b = ALU_W'(elapsed_reg);
            end
            ST_DL: begin
                alu_a   = now_reg;
                alu_b   = ALU_W'(slack_reg);
                alu_sub = 1'b0;
            end
            ST_TICK: begin
                alu_a = now_reg;
                alu_b = deadline_reg[ci];
            end
            default: begin
            end
        endcase
    end

    arc_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .res   (alu_res),
        .carry (alu_carry)
    );

    assign res_zero = (alu_res[TIME_W-1:0] == '0);

    assign pol_req.op   = op_reg;
    assign pol_req.core = core_reg;
    assign pol_req.arm  = arm_reg;

    arc_policy #(
        .NUM_CORES (NUM_CORES)
    ) u_policy (
        .req        (pol_req),
        .mask       (halt_mask_reg),
        .change     (change_reg),
        .lvl        (level_reg),
        .dl_set     (dl_set),
        .res        (pol_res),
        .lvl_c_next (pol_lvl_c)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!in_core_ok) begin
                        state_next = ST_APPLY;
                    end else begin
                        case (func_t'(s_tuser[FUNC_W-1:0]))
                            FN_MILESTONE: state_next = ST_MUL;
                            FN_TICK:      state_next = ST_TICK;
                            default:      state_next = ST_APPLY;
                        endcase
                    end
                end
            end
            ST_MUL: state_next = ST_CMP;
            ST_CMP: begin
                if (!alu_carry) begin
                    state_next = ST_RES;
                end else if (res_zero) begin
                    state_next = ST_APPLY;
                end else begin
                    state_next = ST_SLK;
                end
            end
            ST_SLK:  state_next = ST_APPLY;
            ST_RES:  state_next = ST_DST;
            ST_DST:  state_next = ST_DL;
            ST_DL:   state_next = ST_APPLY;
            ST_TICK: state_next = ST_APPLY;
            ST_APPLY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers: sequencer, configuration, regulator state, result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            halt_mask_reg <= '0;
            change_reg    <= '0;
            for (int k = 0; k < CFG_CORES; k++) begin
                alpha_reg[k]  <= ALPHA_W'(1);
                margin_reg[k] <= '0;
            end
            for (int k = 0; k < NUM_CORES; k++) begin
                level_reg[k]      <= LVL_W'(NUM_CORES);
                last_slack_reg[k] <= '0;
                deadline_reg[k]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_ALPHA0:  alpha_reg[0]  <= cfg_wdata[ALPHA_W-1:0];
                    REG_ALPHA1:  alpha_reg[1]  <= cfg_wdata[ALPHA_W-1:0];
                    REG_ALPHA2:  alpha_reg[2]  <= cfg_wdata[ALPHA_W-1:0];
                    REG_ALPHA3:  alpha_reg[3]  <= cfg_wdata[ALPHA_W-1:0];
                    REG_MARGIN0: margin_reg[0] <= cfg_wdata[TIME_W-1:0];
                    REG_MARGIN1: margin_reg[1] <= cfg_wdata[TIME_W-1:0];
                    REG_MARGIN2: margin_reg[2] <= cfg_wdata[TIME_W-1:0];
                    REG_MARGIN3: margin_reg[3] <= cfg_wdata[TIME_W-1:0];
                    default: begin
                    end
                endcase
            end
            // The last step commits the decision and loads the result together.
            if (state_reg == ST_APPLY && out_free) begin
                halt_mask_reg <= pol_res.mask;
                change_reg    <= pol_res.change;
                m_tvalid_reg  <= 1'b1;
                case (op_reg)
                    OP_HALT: begin
                        level_reg[ci]      <= pol_lvl_c;
                        last_slack_reg[ci] <= slack_reg;
                    end
                    OP_AHEAD: begin
                        level_reg[ci]      <= pol_lvl_c;
                        last_slack_reg[ci] <= '0;
                        if (arm_reg) begin
                            deadline_reg[ci] <= new_dl_reg;
                        end
                    end
                    OP_FINISH: begin
                        level_reg[ci]      <= pol_lvl_c;
                        last_slack_reg[ci] <= '0;
                    end
                    OP_FREE: begin
                        deadline_reg[ci] <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Item payload and intermediate results of the shared adder.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                core_reg    <= in_core;
                elapsed_reg <= s_tdata[ELAPSED_LSB +: TIME_W];
                nominal_reg <= s_tdata[NOMINAL_LSB +: TIME_W];
                now_reg     <= s_tdata[NOW_LSB +: NOW_W];
                arm_reg     <= 1'b0;
                op_reg      <= OP_NONE;
                if (in_core_ok && func_t'(s_tuser[FUNC_W-1:0]) == FN_FINISH) begin
                    op_reg <= OP_FINISH;
                end
            end
            ST_MUL: begin
                setpoint_reg <= product[TIME_W-1:0];
            end
            ST_CMP: begin
                // Behind schedule keeps the slack; on schedule only clears the report.
                slack_reg <= alu_res[TIME_W-1:0];
                op_reg    <= OP_CLEAR;
            end
            ST_SLK: begin
                op_reg <= alu_carry ? OP_HALT : OP_CLEAR;
            end
            ST_RES: begin
                resume_reg <= alu_res[TIME_W-1:0];
            end
            ST_DST: begin
                // Distance to the resume point; armed only below it and with no deadline.
                slack_reg <= alu_res[TIME_W-1:0];
                arm_reg   <= alu_carry && !res_zero && !dl_set[ci];
            end
            ST_DL: begin
                new_dl_reg <= alu_res;
                op_reg     <= OP_AHEAD;
            end
            ST_TICK: begin
                if (!dl_set[ci]) begin
                    op_reg <= OP_NONE;
                end else begin
                    op_reg <= alu_carry ? OP_FREE : OP_HOLD;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    m_tdata_reg <= M_TDATA_W'({pol_res.change, pol_res.mask});
                end
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // Cores beyond the configured count are never reported halted.
    a_mask_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[MASK_W-1:0] >> NUM_CORES) == '0))
        else $error("halted core outside the core count");

    // An accepted item keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened right after accepting an item");

    // A freshly shown result carries the committed halt mask.
    a_result_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (m_tdata[MASK_W-1:0] == halt_mask_reg))
        else $error("result halt mask differs from committed state");
`endif

endmodule

`default_nettype wire

// File: tb/sv/halt_regulator_checker.sv
`default_nettype none

// Watches the event, result and register-write ports of the halt regulator, keeps its own
// model of the per-core halt state and compares every result item with its prediction.
module halt_regulator_checker
    import arc_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // core_id, elapsed_time, nominal_progress, now
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // func
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    // halted_cores, decision_bits
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         mismatch_count,
    output int                         verdicts_pending
);

    typedef struct packed {
        logic [MASK_W-1:0] halted;
        logic [CB_W-1:0]   decision;
    } verdict_t;

    // Register copies.
    logic [ALPHA_W-1:0] scale_q  [CFG_CORES];
    logic [TIME_W-1:0]  margin_q [CFG_CORES];

    // Regulator state.
    logic [MASK_W-1:0]  held_mask;
    logic [CB_W-1:0]    decisions;
    logic [2:0]         level_q    [CFG_CORES];
    logic [TIME_W-1:0]  slack_q    [CFG_CORES];
    logic [NOW_W-1:0]   deadline_q [CFG_CORES];

    verdict_t expected_verdicts[$];

    function automatic void clear_model();
        int k;
        for (k = 0; k < CFG_CORES; k++) begin
            scale_q[k]    = ALPHA_W'(1);
            margin_q[k]   = '0;
            level_q[k]    = 3'(NUM_CORES);
            slack_q[k]    = '0;
            deadline_q[k] = '0;
        end
        held_mask = '0;
        decisions = '0;
    endfunction

    function automatic void hold_core(int k);
        if (k >= NUM_CORES || held_mask[k])
            return;
        held_mask[k] = 1'b1;
        decisions[k] = 1'b1;
    endfunction

    function automatic void free_core(int k);
        if (k >= NUM_CORES || !held_mask[k])
            return;
        held_mask[k]     = 1'b0;
        decisions[k + 4] = 1'b1;
    endfunction

    // A core may only run again when it has no deadline pending and no core's level
    // reaches down to it.
    function automatic bit release_allowed(int k);
        int m;
        if (deadline_q[k] != 0)
            return 1'b0;
        for (m = 0; m < NUM_CORES; m++)
            if (level_q[m] <= k)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void release_upward(int start);
        int k;
        for (k = start; k < NUM_CORES; k++)
            if (release_allowed(k))
                free_core(k);
    endfunction

    function automatic void run_milestone(int c, logic [TIME_W-1:0] el,
                                          logic [TIME_W-1:0] nom, logic [NOW_W-1:0] ts);
        logic [TIME_W-1:0] setpoint;
        logic [TIME_W-1:0] resume;
        logic [TIME_W-1:0] slack;
        logic [TIME_W-1:0] lead;
        int                k;
        int                old_level;
        setpoint  = nom * {{(TIME_W-ALPHA_W){1'b0}}, scale_q[c]};
        resume    = setpoint - margin_q[c];
        decisions = '0;
        if (el > setpoint) begin
            slack = el - setpoint;
            if (slack >= slack_q[c]) begin
                if (level_q[c] > c + 1)
                    level_q[c] = level_q[c] - 3'd1;
                for (k = int'(level_q[c]); k < NUM_CORES; k++)
                    hold_core(k);
                slack_q[c] = slack;
            end
        end else if (el < setpoint) begin
            old_level  = int'(level_q[c]);
            level_q[c] = 3'(NUM_CORES);
            slack_q[c] = '0;
            release_upward(old_level);
            if (el < resume && deadline_q[c] == 0) begin
                lead          = resume - el;
                deadline_q[c] = ts + {{(NOW_W-TIME_W){1'b0}}, lead};
                decisions[c]  = 1'b1;
            end
        end
    endfunction

    function automatic void run_finish(int c);
        decisions  = '0;
        level_q[c] = 3'(NUM_CORES);
        slack_q[c] = '0;
        release_upward(c);
    endfunction

    // Ticks keep the bits already reported and add their own.
    function automatic void run_tick(int c, logic [NOW_W-1:0] ts);
        if (deadline_q[c] == 0)
            return;
        if (ts < deadline_q[c]) begin
            hold_core(c);
        end else begin
            free_core(c);
            deadline_q[c] = '0;
        end
    endfunction

    function automatic verdict_t predict_verdict(logic [FUNC_W-1:0] fn,
                                                 logic [S_TDATA_W-1:0] item);
        verdict_t v;
        int       c;
        c = int'(item[CORE_LSB +: CORE_W]);
        if (c < NUM_CORES) begin
            case (fn)
                FN_MILESTONE: run_milestone(c, item[ELAPSED_LSB +: TIME_W],
                                            item[NOMINAL_LSB +: TIME_W],
                                            item[NOW_LSB +: NOW_W]);
                FN_FINISH:    run_finish(c);
                FN_TICK:      run_tick(c, item[NOW_LSB +: NOW_W]);
                default:      ;
            endcase
        end
        v.halted   = held_mask;
        v.decision = decisions;
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        int       idx;
        if (!aresetn) begin
            clear_model();
            expected_verdicts.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_we) begin
                idx = int'(cfg_addr);
                if (idx < CFG_CORES)
                    scale_q[idx] = cfg_wdata[ALPHA_W-1:0];
                else
                    margin_q[idx - CFG_CORES] = cfg_wdata[TIME_W-1:0];
            end
            if (s_tvalid && s_tready)
                expected_verdicts.push_back(predict_verdict(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result item: halted_cores %h decision_bits %h",
                           m_tdata[3:0], m_tdata[11:4]);
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[3:0] !== want.halted) begin
                        $error("halted_cores: expected %h, actual %h",
                               want.halted, m_tdata[3:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[11:4] !== want.decision) begin
                        $error("decision_bits: expected %h, actual %h",
                               want.decision, m_tdata[11:4]);
                        mismatch_count++;
                    end
                end
            end
        end
        verdicts_pending = expected_verdicts.size();
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

// Stimulus and verdict for the adaptive core halt regulator. The checker instance beside
// the block predicts and compares every result item; this module only produces events,
// register writes and back-pressure, and decides pass or fail at the end.
module tb_top;
    import arc_pkg::*;

    // Generous bound: the run has under a thousand items, even with heavy idling
    // on both sides.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 117;
    localparam int TAIL_CYCLES     = 16;

    // The one func code the block must ignore.
    localparam logic [FUNC_W-1:0] FN_UNKNOWN = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int verdicts_pending;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // The stimulus side keeps the register values it wrote so that milestones can be
    // aimed just above, at, or just below the setpoint of the reporting core.
    logic [ALPHA_W-1:0] alpha_set  [CFG_CORES];
    logic [TIME_W-1:0]  margin_set [CFG_CORES];

    // A slowly advancing global timer, so that armed deadlines are met by ticks both
    // before and after they expire.
    logic [NOW_W-1:0] clock_now;

    adaptive_core_halt_regulator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    halt_regulator_checker verdict_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver decides anew at every edge whether it stalls the next cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Presents one event item and returns in the time step of the edge that accepted it.
    // Valid is left high so that a following item goes out back to back; gaps are
    // inserted before an item, one per cycle, with the sender's idle probability.
    task automatic offer_item(logic [FUNC_W-1:0] fn, logic [CORE_W-1:0] core,
                              logic [TIME_W-1:0] el, logic [TIME_W-1:0] nom,
                              logic [NOW_W-1:0] ts);
        logic [S_TDATA_W-1:0] item;
        item = '0;
        item[CORE_LSB +: CORE_W]    = core;
        item[ELAPSED_LSB +: TIME_W] = el;
        item[NOMINAL_LSB +: TIME_W] = nom;
        item[NOW_LSB +: NOW_W]      = ts;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        s_tuser  <= fn;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Stops sending and waits until every predicted result has been taken. The pending
    // count is read at the falling edge, where the checker has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (verdicts_pending != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Writes every register from alpha_set and margin_set. Called only while the block
    // is idle.
    task automatic load_settings();
        int k;
        for (k = 0; k < CFG_CORES; k++)
            write_reg(cfg_reg_t'(REG_ALPHA0 + k), {{(CFG_DATA_W-ALPHA_W){1'b0}}, alpha_set[k]});
        for (k = 0; k < CFG_CORES; k++)
            write_reg(cfg_reg_t'(REG_MARGIN0 + k), margin_set[k]);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // One random item. Most items are milestones aimed relative to the setpoint and ticks
    // near the running timer, which is what drives the halt levels and deadlines deep;
    // the rest are finishes, ignored codes and items with fully random content.
    task automatic send_random_item();
        int                 pick;
        int                 kind;
        logic [CORE_W-1:0]  c;
        logic [TIME_W-1:0]  nom;
        logic [TIME_W-1:0]  el;
        logic [TIME_W-1:0]  setpoint;
        logic [NOW_W-1:0]   ts;
        pick      = $urandom_range(0, 99);
        kind      = $urandom_range(0, 99);
        c         = CORE_W'($urandom_range(0, 3));
        clock_now = clock_now + $urandom_range(0, 300);
        if (pick < 45) begin
            nom      = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
            setpoint = nom * {{(TIME_W-ALPHA_W){1'b0}}, alpha_set[c]};
            if (kind < 40)
                el = setpoint + $urandom_range(1, 300);
            else if (kind < 85)
                el = setpoint - $urandom_range(1, 2000);
            else
                el = setpoint;
            offer_item(FN_MILESTONE, c, el, nom, clock_now);
        end else if (pick < 65) begin
            if (kind < 70)
                ts = clock_now + $urandom_range(0, 2500);
            else if (kind < 85)
                ts = {$urandom, $urandom};
            else
                ts = '1;
            offer_item(FN_TICK, c, $urandom, $urandom, ts);
        end else if (pick < 73) begin
            offer_item(FN_FINISH, c, $urandom, $urandom, {$urandom, $urandom});
        end else if (pick < 75) begin
            offer_item(FN_UNKNOWN, c, $urandom, $urandom, {$urandom, $urandom});
        end else begin
            offer_item(FUNC_W'($urandom_range(0, 3)), c, $urandom, $urandom,
                       {$urandom, $urandom});
        end
    endtask

    initial begin
        int phase;
        int n;
        int k;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed settings: one core scaled by zero, one by the largest factor with the
        // largest margin, so that its resume point wraps above its setpoint.
        alpha_set  = '{8'd1, 8'd2, 8'd255, 8'd0};
        margin_set = '{32'd100, 32'd0, 32'hFFFF_FFFF, 32'd50};
        load_settings();

        // A tick for a core with no deadline does nothing, and an unknown func only
        // reports the current state.
        offer_item(FN_TICK, 2'd0, '0, '0, '0);
        offer_item(FN_UNKNOWN, 2'd1, '1, '1, '1);
        // Core 3 scaled by zero and reporting zero time is exactly on schedule.
        offer_item(FN_MILESTONE, 2'd3, 32'd0, 32'd10, 64'd0);
        // Core 1 falls behind, then by the same slack again (which deepens its level once
        // more), then by less, which must not deepen its level.
        offer_item(FN_MILESTONE, 2'd1, 32'd25, 32'd10, 64'd1);
        offer_item(FN_MILESTONE, 2'd1, 32'd25, 32'd10, 64'd2);
        offer_item(FN_MILESTONE, 2'd1, 32'd23, 32'd10, 64'd3);
        // Core 0 far behind three times, walking its level down to its floor.
        offer_item(FN_MILESTONE, 2'd0, '1, 32'd100, 64'd4);
        offer_item(FN_MILESTONE, 2'd0, '1, 32'd100, 64'd5);
        offer_item(FN_MILESTONE, 2'd0, '1, 32'd100, 64'd6);
        // Core 1 well ahead arms its deadline; core 0 finishing releases what it may.
        offer_item(FN_MILESTONE, 2'd1, 32'd0, 32'd10, 64'd10);
        offer_item(FN_FINISH, 2'd0, '0, '0, '0);
        // Ticks before and at the deadline of core 1 add their bits to those held.
        offer_item(FN_TICK, 2'd1, '0, '0, 64'd20);
        offer_item(FN_TICK, 2'd1, '0, '0, 64'd30);
        // Core 2 arms a deadline whose sum wraps to zero, which counts as none.
        offer_item(FN_MILESTONE, 2'd2, 32'd6, 32'd1, ~64'd249);
        offer_item(FN_TICK, 2'd2, '0, '0, '0);
        // Largest nominal progress with zero time, then a tick at the timer's top.
        offer_item(FN_MILESTONE, 2'd0, 32'd0, '1, '1);
        offer_item(FN_TICK, 2'd0, '0, '0, '1);
        // Releasing a core that is not halted, and extremes on a zero-scaled core.
        offer_item(FN_FINISH, 2'd3, '1, '1, '1);
        offer_item(FN_MILESTONE, 2'd3, '1, '1, '1);
        offer_item(FN_FINISH, 2'd2, '0, '0, '0);
        offer_item(FN_FINISH, 2'd1, '0, '0, '0);

        clock_now = 64'd1000;

        // Random phases. Each phase cycles through the idling modes and loads a new set
        // of registers, the extremes among them, once everything in flight has arrived.
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 65;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 65;
                end
                default: begin
                    tx_idle_pct  = 8;
                    rx_stall_pct = 8;
                end
            endcase
            for (k = 0; k < CFG_CORES; k++) begin
                case (phase)
                    0: begin
                        alpha_set[k]  = 8'd1;
                        margin_set[k] = $urandom_range(0, 1500);
                    end
                    1: begin
                        alpha_set[k]  = 8'd255;
                        margin_set[k] = '1;
                    end
                    2: begin
                        alpha_set[k]  = (k == 0) ? 8'd0 : 8'($urandom_range(1, 6));
                        margin_set[k] = '0;
                    end
                    default: begin
                        alpha_set[k]  = ($urandom_range(0, 3) == 0) ?
                                        8'($urandom_range(0, 255)) : 8'($urandom_range(1, 8));
                        margin_set[k] = ($urandom_range(0, 3) == 0) ?
                                        $urandom : $urandom_range(0, 3000);
                    end
                endcase
            end
            load_settings();
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Now and then the sender holds off until the block has emptied.
                if ($urandom_range(0, 49) == 0)
                    drain();
                send_random_item();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatch_count == 0 && verdicts_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: adaptive_core_halt_regulator.f
sv/arc_pkg.sv
sv/arc_alu.sv
sv/arc_policy.sv
sv/adaptive_core_halt_regulator.sv
tb/sv/halt_regulator_checker.sv
tb/sv/tb_top.sv
